>>> hw/rtl/lre_pkg.sv
`default_nettype none

package lre_pkg;

    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 40;
    localparam int IDX_OUT_W = 4;
    localparam int VAL_OUT_W = 32;

    typedef struct packed {
        logic load;
        logic start;
        logic step;
        logic first;
        logic tail;
    } t_node_ctl;

endpackage

`default_nettype wire

>>> hw/rtl/lre_mem.sv
`default_nettype none

module lre_mem #(
    parameter int W     = 96,
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [W-1:0]  i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [W-1:0]  o_rdata
);

    logic [W-1:0] r_mem [DEPTH];
    logic [W-1:0] r_rd;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_we && (i_waddr == i_raddr)) begin
            r_rd <= i_wdata;
        end else begin
            r_rd <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rd;

endmodule

`default_nettype wire

>>> hw/rtl/lre_node.sv
`default_nettype none

module lre_node #(
    parameter int KW = 32,
    parameter int IW = 4
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire lre_pkg::t_node_ctl i_ctl,
    input  wire logic [IW-1:0]     i_idx,
    input  wire logic [KW-1:0]     i_key,
    input  wire logic [3*KW-1:0]   i_rd_word,
    output logic                   o_we,
    output logic      [3*KW-1:0]   o_wr_word,
    output logic                   o_found,
    output logic      [IW-1:0]     o_widx,
    output logic      [KW-1:0]     o_wval
);
    import lre_pkg::*;

    logic [KW-1:0] w_own;
    logic [KW-1:0] w_best;
    logic [KW-1:0] w_out;
    logic [KW-1:0] w_inc;
    logic [KW-1:0] n_best;
    logic [KW-1:0] n_out;
    logic          w_elect;

    logic [KW-1:0] r_carry;
    logic [KW-1:0] r_wrap;
    logic          r_found;
    logic [IW-1:0] r_widx;
    logic [KW-1:0] r_wval;

    assign w_own  = i_rd_word[3*KW-1:2*KW];
    assign w_best = i_rd_word[2*KW-1:KW];
    assign w_out  = i_rd_word[KW-1:0];
    assign w_inc  = i_ctl.first ? r_wrap : r_carry;

    always_comb begin
        n_best  = w_best;
        n_out   = w_out;
        w_elect = 1'b0;
        if ($signed(w_inc) > $signed(w_best)) begin
            n_best = w_inc;
            n_out  = w_inc;
        end else if (w_inc == w_own) begin
            n_best  = w_own;
            w_elect = 1'b1;
        end
    end

    assign o_we      = i_ctl.step;
    assign o_wr_word = {w_own, n_best, n_out};

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_wrap <= i_key;
        end else if (i_ctl.step && i_ctl.tail) begin
            r_wrap <= n_out;
        end
        if (i_ctl.step) begin
            r_carry <= w_out;
        end
        if (i_ctl.step && w_elect && (!r_found || (i_idx >= r_widx))) begin
            r_widx <= i_idx;
            r_wval <= w_own;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else if (i_ctl.start) begin
            r_found <= 1'b0;
        end else if (i_ctl.step && w_elect) begin
            r_found <= 1'b1;
        end
    end

    assign o_found = r_found;
    assign o_widx  = r_widx;
    assign o_wval  = r_wval;

endmodule

`default_nettype wire

>>> hw/rtl/ring_leader_election.sv
// Loading: one node id per cycle, an id is taken every cycle while loading.
// Election: one node per cycle through the node-state memory port, N rounds
// of N nodes; the result word is registered after a drain state.
// A new ring loads while the previous result word waits on the output.
// Synchronous active-low reset clears the control state and the elected mark;
// the node-state memory holds no reset value.
`default_nettype none

module ring_leader_election #(
    parameter int MAX_NODES   = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    input  wire logic [lre_pkg::S_TDATA_W-1:0]  i_s_axis_tdata,  // node_value
    input  wire logic                           i_s_axis_tlast,  // last_node
    output logic                                o_m_axis_tvalid,
    input  wire logic                           i_m_axis_tready,
    output logic      [lre_pkg::M_TDATA_W-1:0]  o_m_axis_tdata,  // winner_index, winner_value, pad
    output logic                                o_m_axis_tuser   // found
);
    import lre_pkg::*;

    localparam int KW = (VALUE_WIDTH < 32) ? VALUE_WIDTH : 32;
    localparam int IW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int CW = $clog2(MAX_NODES + 1);

    localparam logic [1:0] ST_LOAD  = 2'd0;
    localparam logic [1:0] ST_RUN   = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    logic [1:0]    r_state;
    logic [CW-1:0] r_count;
    logic [IW-1:0] r_rd_idx;
    logic [IW-1:0] r_round;
    logic          r_s2_v;
    logic [IW-1:0] r_s2_idx;
    logic          r_s2_first;
    logic          r_s2_tail;
    logic          r_mv;
    logic [M_TDATA_W-1:0] r_m_tdata;
    logic [M_TDATA_W-1:0] n_m_tdata;
    logic          r_m_tuser;

    logic          w_s_acc;
    logic          w_store;
    logic [KW-1:0] w_key;
    logic [CW-1:0] w_last;
    logic          w_tail;
    logic          w_issue;
    logic          w_emit;
    t_node_ctl     w_ctl;

    logic            w_we;
    logic [IW-1:0]   w_waddr;
    logic [3*KW-1:0] w_wdata;
    logic [3*KW-1:0] w_rdata;
    logic            w_node_we;
    logic [3*KW-1:0] w_node_wdata;
    logic            w_found;
    logic [IW-1:0]   w_widx;
    logic [KW-1:0]   w_wval;
    logic [IW+IDX_OUT_W-1:0] w_widx_ext;
    logic [VAL_OUT_W-1:0]    w_wval_ext;

    assign o_s_axis_tready = (r_state == ST_LOAD);
    assign w_s_acc = i_s_axis_tvalid && o_s_axis_tready;
    assign w_store = w_s_acc && (r_count < CW'(MAX_NODES));
    assign w_key   = i_s_axis_tdata[KW-1:0];
    assign w_last  = CW'(r_count - 1'b1);
    assign w_tail  = (CW'(r_rd_idx) == w_last);
    assign w_issue = (r_state == ST_RUN);
    assign w_emit  = (r_state == ST_DONE) && (!r_mv || i_m_axis_tready);

    assign w_ctl.load  = w_store;
    assign w_ctl.start = w_s_acc && i_s_axis_tlast;
    assign w_ctl.step  = r_s2_v;
    assign w_ctl.first = r_s2_first;
    assign w_ctl.tail  = r_s2_tail;

    assign w_we    = w_store || w_node_we;
    assign w_waddr = w_store ? r_count[IW-1:0] : r_s2_idx;
    assign w_wdata = w_store ? {w_key, w_key, w_key} : w_node_wdata;

    lre_mem #(
        .W     (3 * KW),
        .DEPTH (MAX_NODES),
        .AW    (IW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (r_rd_idx),
        .o_rdata (w_rdata)
    );

    lre_node #(
        .KW (KW),
        .IW (IW)
    ) u_node (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_ctl),
        .i_idx     (r_s2_idx),
        .i_key     (w_key),
        .i_rd_word (w_rdata),
        .o_we      (w_node_we),
        .o_wr_word (w_node_wdata),
        .o_found   (w_found),
        .o_widx    (w_widx),
        .o_wval    (w_wval)
    );

    assign w_widx_ext = {{IDX_OUT_W{1'b0}}, w_widx};
    assign w_wval_ext = VAL_OUT_W'($signed(w_wval));

    always_comb begin
        n_m_tdata = '0;
        if (w_found) begin
            n_m_tdata[IDX_OUT_W-1:0] = w_widx_ext[IDX_OUT_W-1:0];
            n_m_tdata[IDX_OUT_W+VAL_OUT_W-1:IDX_OUT_W] = w_wval_ext;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_LOAD;
            r_count  <= '0;
            r_rd_idx <= '0;
            r_round  <= '0;
            r_s2_v   <= 1'b0;
            r_mv     <= 1'b0;
        end else begin
            r_s2_v <= w_issue;
            if (o_m_axis_tvalid && i_m_axis_tready && !w_emit) begin
                r_mv <= 1'b0;
            end
            case (r_state)
                ST_LOAD: begin
                    if (w_store) begin
                        r_count <= CW'(r_count + 1'b1);
                    end
                    if (w_s_acc && i_s_axis_tlast) begin
                        r_state  <= ST_RUN;
                        r_rd_idx <= '0;
                        r_round  <= '0;
                    end
                end
                ST_RUN: begin
                    if (w_tail) begin
                        r_rd_idx <= '0;
                        if (CW'(r_round) == w_last) begin
                            r_state <= ST_DRAIN;
                        end else begin
                            r_round <= IW'(r_round + 1'b1);
                        end
                    end else begin
                        r_rd_idx <= IW'(r_rd_idx + 1'b1);
                    end
                end
                ST_DRAIN: begin
                    r_state <= ST_DONE;
                end
                ST_DONE: begin
                    if (w_emit) begin
                        r_mv    <= 1'b1;
                        r_count <= '0;
                        r_state <= ST_LOAD;
                    end
                end
                default: begin
                    r_state <= ST_LOAD;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_issue) begin
            r_s2_idx   <= r_rd_idx;
            r_s2_first <= (r_rd_idx == '0);
            r_s2_tail  <= w_tail;
        end
        if (w_emit) begin
            r_m_tuser <= w_found;
            r_m_tdata <= n_m_tdata;
        end
    end

    assign o_m_axis_tvalid = r_mv;
    assign o_m_axis_tdata  = r_m_tdata;
    assign o_m_axis_tuser  = r_m_tuser;

`ifndef ASSERT_OFF
    a_step_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2_v |-> (r_state == ST_RUN || r_state == ST_DRAIN))
        else $error("node step outside election");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_NODES))
        else $error("node count beyond capacity");

    a_last_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_s_acc && i_s_axis_tlast) |=> (r_state == ST_RUN))
        else $error("last word did not start election");

    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tuser) |-> (o_m_axis_tdata == '0))
        else $error("no winner but nonzero result");
`endif

endmodule

`default_nettype wire

>>> verif/ring_leader_election_checker.sv
`default_nettype none

module ring_leader_election_checker (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_s_axis_tvalid,
    input  wire logic                           i_s_axis_tready,
    input  wire logic [lre_pkg::S_TDATA_W-1:0]  i_s_axis_tdata,  // node_value
    input  wire logic                           i_s_axis_tlast,  // last_node
    input  wire logic                           i_m_axis_tvalid,
    input  wire logic                           i_m_axis_tready,
    input  wire logic [lre_pkg::M_TDATA_W-1:0]  i_m_axis_tdata,  // winner_index, winner_value, pad
    input  wire logic                           i_m_axis_tuser,  // found
    output int                                  o_fail_count,
    output int                                  o_pending,
    output int                                  o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NODE_SLOTS = 16;

    typedef struct {
        logic                                   found;
        logic [lre_pkg::IDX_OUT_W-1:0]          index;
        logic signed [lre_pkg::VAL_OUT_W-1:0]   value;
    } t_election;

    logic signed [31:0] own_id    [NODE_SLOTS];
    logic signed [31:0] leader    [NODE_SLOTS];
    logic signed [31:0] send_id   [NODE_SLOTS];
    logic signed [31:0] recv_id   [NODE_SLOTS];
    bit                 won       [NODE_SLOTS];
    int                 loaded = 0;
    t_election          elections_due [$];
    int                 fail_count = 0;
    int                 checked = 0;

    task automatic report_mismatch(input string msg);
        $display("%0t ns: %s", $realtime, msg);
        fail_count++;
    endtask

    // run one round per node, then pick the highest elected position
    task automatic elect_leader();
        int        n;
        t_election res;
        n = loaded;
        for (int i = 0; i < NODE_SLOTS; i++) won[i] = 1'b0;
        for (int r = 0; r < n; r++) begin
            for (int i = 0; i < n; i++) recv_id[(i + 1) % n] = send_id[i];
            for (int i = 0; i < n; i++) begin
                if (recv_id[i] > leader[i]) begin
                    leader[i]  = recv_id[i];
                    send_id[i] = recv_id[i];
                end else if (recv_id[i] == own_id[i]) begin
                    leader[i] = own_id[i];
                    won[i]    = 1'b1;
                end
            end
        end
        res.found = 1'b0;
        res.index = '0;
        res.value = '0;
        for (int i = 0; i < n; i++) begin
            if (won[i]) begin
                res.found = 1'b1;
                res.index = 4'(i);
                res.value = own_id[i];
            end
        end
        loaded = 0;
        elections_due.push_back(res);
    endtask

    always @(posedge i_clk) begin
        t_election want;
        if (i_rst_n) begin
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                if (elections_due.size() == 0) begin
                    report_mismatch("result word with no election pending");
                end else begin
                    want = elections_due.pop_front();
                    if (i_m_axis_tuser !== want.found)
                        report_mismatch($sformatf("election %0d found: got %0b expected %0b",
                                        checked, i_m_axis_tuser, want.found));
                    if (i_m_axis_tdata[3:0] !== want.index)
                        report_mismatch($sformatf("election %0d index: got %0d expected %0d",
                                        checked, i_m_axis_tdata[3:0], want.index));
                    if (i_m_axis_tdata[35:4] !== want.value)
                        report_mismatch($sformatf("election %0d value: got %0d expected %0d",
                                        checked, $signed(i_m_axis_tdata[35:4]), want.value));
                    checked++;
                end
            end
            if (i_s_axis_tvalid && i_s_axis_tready) begin
                // drop ids once the ring is full
                if (loaded < NODE_SLOTS) begin
                    own_id[loaded]  = i_s_axis_tdata;
                    leader[loaded]  = i_s_axis_tdata;
                    send_id[loaded] = i_s_axis_tdata;
                    loaded++;
                end
                if (i_s_axis_tlast) elect_leader();
            end
        end
        o_fail_count <= fail_count;
        o_pending    <= elections_due.size();
        o_checked    <= checked;
    end

endmodule

`default_nettype wire

>>> verif/ring_leader_election_tb.sv
`default_nettype none

module ring_leader_election_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_WORDS   = 1800;
    localparam int DIRECTED_WORDS = 24;
    localparam int ID_ANY         = 0;
    localparam int ID_NARROW      = 1;
    localparam int ID_EXTREME     = 2;

    logic                           clk      = 1'b0;
    logic                           rst_n    = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic [lre_pkg::S_TDATA_W-1:0]  s_tdata  = '0;    // node_value
    logic                           s_tlast  = 1'b0;  // last_node
    logic                           m_tready = 1'b0;
    wire logic                      s_tready;
    wire logic                      m_tvalid;
    wire logic [lre_pkg::M_TDATA_W-1:0] m_tdata;      // winner_index, winner_value, pad
    wire logic                      m_tuser;          // found

    int idle_pct    = 0;
    int stall_pct   = 0;
    int words_sent  = 0;
    int rings_sent  = 0;
    int fail_count;
    int pending;
    int checked;

    ring_leader_election DUT (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tlast  (s_tlast),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser)
    );

    ring_leader_election_checker u_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .i_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tlast  (s_tlast),
        .i_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .i_m_axis_tdata  (m_tdata),
        .i_m_axis_tuser  (m_tuser),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_checked       (checked)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk) begin
        if (!rst_n) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    initial begin
        #5ms;
        $display("ring_leader_election test failed");
        $finish;
    end

    task automatic send_word(input logic [31:0] id, input logic last);
        while ($urandom_range(0, 99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= id;
        s_tlast  <= last;
        do @(posedge clk); while (!s_tready);
        words_sent++;
        if (last) rings_sent++;
    endtask

    function automatic logic [31:0] pick_id(input int mode);
        case (mode)
            ID_NARROW: return 32'(int'($urandom_range(0, 4)) - 2);
            ID_EXTREME: begin
                case ($urandom_range(0, 3))
                    0: return 32'h7FFF_FFFF;
                    1: return 32'h8000_0000;
                    2: return 32'hFFFF_FFFF;
                    default: return 32'h0000_0000;
                endcase
            end
            default: return $urandom();
        endcase
    endfunction

    initial begin
        int size;
        int mode;
        int phase;
        int pick;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // single-node rings at both extremes, then a two-node ring of both
        send_word(32'h7FFF_FFFF, 1'b1);
        send_word(32'h8000_0000, 1'b1);
        send_word(32'h8000_0000, 1'b0);
        send_word(32'h7FFF_FFFF, 1'b1);
        // equal ids everywhere
        send_word(32'hFFFF_FFFF, 1'b0);
        send_word(32'hFFFF_FFFF, 1'b0);
        send_word(32'hFFFF_FFFF, 1'b1);
        // overfull ring: the closing id is dropped
        for (int k = 0; k < 16; k++) send_word(32'(k - 8), 1'b0);
        send_word(32'h7FFF_FFFF, 1'b1);

        while (words_sent < DIRECTED_WORDS + RANDOM_WORDS) begin
            phase = (words_sent - DIRECTED_WORDS) * 4 / RANDOM_WORDS;
            case (phase)
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 69; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 69; end
                default: begin idle_pct = 6;  stall_pct = 6;  end
            endcase
            pick = $urandom_range(0, 99);
            if (pick < 70)      size = $urandom_range(1, 5);
            else if (pick < 92) size = $urandom_range(6, 16);
            else                size = $urandom_range(17, 20);
            pick = $urandom_range(0, 9);
            if (pick < 5)      mode = ID_ANY;
            else if (pick < 8) mode = ID_NARROW;
            else               mode = ID_EXTREME;
            for (int k = 0; k < size; k++) send_word(pick_id(mode), k == size - 1);
        end
        s_tvalid <= 1'b0;

        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (300) @(posedge clk);

        $display("covered %0d id words in %0d rings, %0d elections checked",
                 words_sent, rings_sent, checked);
        $display("pacing: free flow, sparse sender, stalling receiver, light mixed idling");
        if (pending != 0) $display("%0d elections never reported", pending);
        if (fail_count == 0 && pending == 0) begin
            $display("ring_leader_election test passed");
        end else begin
            $display("ring_leader_election test failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

>>> sim.f
hw/rtl/lre_pkg.sv
hw/rtl/lre_mem.sv
hw/rtl/lre_node.sv
hw/rtl/ring_leader_election.sv
verif/ring_leader_election_checker.sv
verif/ring_leader_election_tb.sv
